// File: rtl/core/vertex_bounding_box_normalizer_top_assert.svh
// Assertion macros for the vertex bounding box normaliser checker.
// Depends on i_clk and i_rst_n being visible where the macros are used.
`ifndef VERTEX_BOUNDING_BOX_NORMALIZER_TOP_ASSERT_SVH
`define VERTEX_BOUNDING_BOX_NORMALIZER_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define VBN_CHK_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vbn check failed");

// next-cycle implication, masked during reset
`define VBN_CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vbn check failed");

// next-cycle implication, live during reset
`define VBN_CHK_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("vbn reset check failed");

`endif

// File: rtl/core/vbn_pkg.sv
// Package for the vertex bounding box normaliser: types and fixed constants.
// No dependencies.
`default_nettype none
package vbn_pkg;
    localparam int COORD_W = 32;
    localparam int AXES    = 3;
    localparam int VTX_W   = COORD_W * AXES;

    localparam logic [COORD_W-1:0] SIDE_RESET = 32'd131072;
    localparam logic [COORD_W-1:0] SAT_MAX    = 32'h7FFF_FFFF;
    localparam logic [1:0]         LAST_AXIS  = 2'd2;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] lo;
        logic [AXES-1:0][COORD_W-1:0] hi;
        logic [AXES-1:0]              flat;
        logic                         dropped;
    } t_job;
endpackage
`default_nettype wire

// File: rtl/core/vbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module vbn_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/vbn_front.sv
// Front end: accepts vertices, writes the store, tracks the box, posts a job on last.
// Depends on vbn_pkg.
`default_nettype none
module vbn_front #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [vbn_pkg::COORD_W-1:0]       i_x_in,
    input  wire logic [vbn_pkg::COORD_W-1:0]       i_y_in,
    input  wire logic [vbn_pkg::COORD_W-1:0]       i_z_in,
    input  wire logic                              i_last_in,
    input  wire logic                              i_back_busy,
    input  wire logic                              i_job_pop,
    output logic                                   o_wr_en,
    output logic [$clog2(MAX_VERTICES)-1:0]        o_wr_addr,
    output logic [vbn_pkg::VTX_W-1:0]              o_wr_data,
    output logic                                   o_job_vld,
    output vbn_pkg::t_job                          o_job,
    output logic [$clog2(MAX_VERTICES+1)-1:0]      o_job_n
);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [CW-1:0]                                   r_count;
    logic                                            r_ovf;
    logic [vbn_pkg::AXES-1:0][vbn_pkg::COORD_W-1:0]  r_lo;
    logic [vbn_pkg::AXES-1:0][vbn_pkg::COORD_W-1:0]  r_hi;
    logic [vbn_pkg::AXES-1:0][vbn_pkg::COORD_W-1:0]  n_lo;
    logic [vbn_pkg::AXES-1:0][vbn_pkg::COORD_W-1:0]  n_hi;
    logic [vbn_pkg::AXES-1:0][vbn_pkg::COORD_W-1:0]  w_v;
    logic                                            w_acc;
    logic                                            w_room;
    logic [CW-1:0]                                   n_count;
    logic                                            n_ovf;
    logic                                            r_job_vld;

    assign full   = r_job_vld | i_back_busy;
    assign w_acc  = push & ~full;
    assign w_room = r_count < CW'(MAX_VERTICES);
    assign w_v    = {i_z_in, i_y_in, i_x_in};

    assign o_wr_en   = w_acc & w_room;
    assign o_wr_addr = r_count[AW-1:0];
    assign o_wr_data = w_v;

    always_comb begin
        for (int a = 0; a < vbn_pkg::AXES; a++) begin
            n_lo[a] = r_lo[a];
            n_hi[a] = r_hi[a];
            if (w_room) begin
                if (r_count == '0 || $signed(w_v[a]) < $signed(r_lo[a])) begin
                    n_lo[a] = w_v[a];
                end
                if (r_count == '0 || $signed(w_v[a]) > $signed(r_hi[a])) begin
                    n_hi[a] = w_v[a];
                end
            end
        end
        n_count = w_room ? r_count + CW'(1) : r_count;
        n_ovf   = r_ovf | ~w_room;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_lo      <= '0;
            r_hi      <= '0;
            r_job_vld <= 1'b0;
        end else begin
            if (i_job_pop) begin
                r_job_vld <= 1'b0;
            end
            if (w_acc) begin
                if (i_last_in) begin
                    r_count   <= '0;
                    r_ovf     <= 1'b0;
                    r_lo      <= '0;
                    r_hi      <= '0;
                    r_job_vld <= 1'b1;
                end else begin
                    r_count <= n_count;
                    r_ovf   <= n_ovf;
                    r_lo    <= n_lo;
                    r_hi    <= n_hi;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_last_in) begin
            o_job.lo      <= n_lo;
            o_job.hi      <= n_hi;
            o_job.dropped <= n_ovf;
            for (int a = 0; a < vbn_pkg::AXES; a++) begin
                o_job.flat[a] <= (n_lo[a] == n_hi[a]);
            end
            o_job_n <= n_count;
        end
    end

    assign o_job_vld = r_job_vld;
endmodule
`default_nettype wire

// File: rtl/core/vbn_div.sv
// Restoring divider, 64 by 32 bits, one quotient bit per cycle.
// No dependencies; quotient must fit in 32 bits.
`default_nettype none
module vbn_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quot
);
    logic [31:0] r_rem;
    logic [31:0] r_lo;
    logic [31:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_done;
    logic [32:0] w_t;
    logic        w_ge;

    assign w_t  = {r_rem, r_lo[31]};
    assign w_ge = w_t >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= 6'd32;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[63:32];
            r_lo  <= i_dividend[31:0];
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? 32'(w_t - {1'b0, r_div}) : w_t[31:0];
            r_lo  <= {r_lo[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_lo;
endmodule
`default_nettype wire

// File: rtl/core/vbn_back.sv
// Back end: sweeps the store for a posted job and maps each axis into the box.
// Depends on vbn_pkg and vbn_div.
`default_nettype none
module vbn_back #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [vbn_pkg::COORD_W-1:0]       i_side,
    input  wire logic                              i_job_vld,
    input  wire vbn_pkg::t_job                     i_job,
    input  wire logic [$clog2(MAX_VERTICES+1)-1:0] i_job_n,
    output logic                                   o_job_pop,
    output logic                                   o_busy,
    output logic                                   o_rd_en,
    output logic [$clog2(MAX_VERTICES)-1:0]        o_rd_addr,
    input  wire logic [vbn_pkg::VTX_W-1:0]         i_rd_data,
    input  wire logic                              pop,
    output logic                                   empty,
    output logic [vbn_pkg::COORD_W-1:0]            o_x_out,
    output logic [vbn_pkg::COORD_W-1:0]            o_y_out,
    output logic [vbn_pkg::COORD_W-1:0]            o_z_out,
    output logic                                   o_last_out,
    output logic [vbn_pkg::AXES-1:0]               o_flat_axes,
    output logic                                   o_dropped
);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_AXIS  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIVGO = 3'd5;
    localparam logic [2:0] S_DIVW  = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]                                      r_state;
    logic [2:0]                                      n_state;
    vbn_pkg::t_job                                   r_info;
    logic [CW-1:0]                                   r_n;
    logic [AW-1:0]                                   r_idx;
    logic [1:0]                                      r_axis;
    logic [vbn_pkg::VTX_W-1:0]                       r_vtx;
    logic [31:0]                                     r_d;
    logic [31:0]                                     r_r;
    logic [63:0]                                     r_prod;
    logic [vbn_pkg::AXES-1:0][vbn_pkg::COORD_W-1:0]  r_res;
    logic                                            r_out_vld;
    logic [32:0]                                     w_d;
    logic [32:0]                                     w_r;
    logic [31:0]                                     w_c;
    logic [31:0]                                     w_lo;
    logic [31:0]                                     w_hi;
    logic                                            w_div_done;
    logic [31:0]                                     w_quot;
    logic [33:0]                                     w_off;
    logic [31:0]                                     w_sat;
    logic                                            w_last_v;
    logic                                            w_emit;

    assign w_c  = r_vtx[r_axis*vbn_pkg::COORD_W +: vbn_pkg::COORD_W];
    assign w_lo = r_info.lo[r_axis];
    assign w_hi = r_info.hi[r_axis];
    assign w_d  = {w_c[31], w_c} - {w_lo[31], w_lo};
    assign w_r  = {w_hi[31], w_hi} - {w_lo[31], w_lo};

    vbn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIVGO),
        .i_dividend (r_prod + {33'd0, r_r[31:1]}),
        .i_divisor  (r_r),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_off = {2'b00, w_quot} - {3'b000, i_side[31:1]};
    assign w_sat = (!w_off[33] && w_off[32:31] != 2'b00) ? vbn_pkg::SAT_MAX : w_off[31:0];

    assign w_last_v = (CW'(r_idx) + CW'(1)) == r_n;
    assign w_emit   = (r_state == S_EMIT) && !r_out_vld;

    assign o_job_pop = (r_state == S_IDLE) && i_job_vld;
    assign o_busy    = r_state != S_IDLE;
    assign o_rd_en   = r_state == S_READ;
    assign o_rd_addr = r_idx;
    assign empty     = ~r_out_vld;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_job_vld) n_state = S_READ;
            S_READ:  n_state = S_LOAD;
            S_LOAD:  n_state = S_AXIS;
            S_AXIS: begin
                if (!r_info.flat[r_axis]) begin
                    n_state = S_MUL;
                end else if (r_axis == vbn_pkg::LAST_AXIS) begin
                    n_state = S_EMIT;
                end
            end
            S_MUL:   n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIVW;
            S_DIVW: begin
                if (w_div_done) begin
                    n_state = (r_axis == vbn_pkg::LAST_AXIS) ? S_EMIT : S_AXIS;
                end
            end
            S_EMIT: begin
                if (!r_out_vld) begin
                    n_state = w_last_v ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_info <= i_job;
            r_n    <= i_job_n;
            r_idx  <= '0;
        end
        if (r_state == S_LOAD) begin
            r_vtx  <= i_rd_data;
            r_axis <= '0;
        end
        if (r_state == S_AXIS) begin
            r_d <= w_d[31:0];
            r_r <= w_r[31:0];
            if (r_info.flat[r_axis]) begin
                r_res[r_axis] <= '0;
                r_axis        <= r_axis + 2'd1;
            end
        end
        if (r_state == S_MUL) begin
            r_prod <= r_d * i_side;
        end
        if (r_state == S_DIVW && w_div_done) begin
            r_res[r_axis] <= w_sat;
            r_axis        <= r_axis + 2'd1;
        end
        if (w_emit) begin
            o_x_out     <= r_res[0];
            o_y_out     <= r_res[1];
            o_z_out     <= r_res[2];
            o_last_out  <= w_last_v;
            o_flat_axes <= r_info.flat;
            o_dropped   <= r_info.dropped;
            r_idx       <= r_idx + AW'(1);
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/vertex_bounding_box_normalizer_top.sv
// Loading: one vertex per cycle while full is low; the last vertex posts the set
// to the back end. Emission: per vertex a store read, then per axis with extent
// one 32x32 multiply and a bit-serial divide; a flat axis skips both.
// The input stays full from the last vertex until the final result is formed.
// Reset (synchronous, active low) clears the box, counts and queues; side length
// returns to 2.0. The vertex store is not cleared.
`default_nettype none
module vertex_bounding_box_normalizer_top #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [vbn_pkg::COORD_W-1:0] i_x_in,
    input  wire logic [vbn_pkg::COORD_W-1:0] i_y_in,
    input  wire logic [vbn_pkg::COORD_W-1:0] i_z_in,
    input  wire logic                        i_last_in,
    input  wire logic                        i_cfg_we,
    input  wire logic [vbn_pkg::COORD_W-1:0] i_cfg_wdata,
    input  wire logic                        pop,
    output logic                             empty,
    output logic [vbn_pkg::COORD_W-1:0]      o_x_out,
    output logic [vbn_pkg::COORD_W-1:0]      o_y_out,
    output logic [vbn_pkg::COORD_W-1:0]      o_z_out,
    output logic                             o_last_out,
    output logic [vbn_pkg::AXES-1:0]         o_flat_axes,
    output logic                             o_dropped
);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic [vbn_pkg::COORD_W-1:0] r_side;
    logic                        w_wr_en;
    logic [AW-1:0]               w_wr_addr;
    logic [vbn_pkg::VTX_W-1:0]   w_wr_data;
    logic                        w_rd_en;
    logic [AW-1:0]               w_rd_addr;
    logic [vbn_pkg::VTX_W-1:0]   w_rd_data;
    logic                        w_job_vld;
    vbn_pkg::t_job               w_job;
    logic [CW-1:0]               w_job_n;
    logic                        w_job_pop;
    logic                        w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= vbn_pkg::SIDE_RESET;
        end else if (i_cfg_we) begin
            r_side <= i_cfg_wdata;
        end
    end

    vbn_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_x_in      (i_x_in),
        .i_y_in      (i_y_in),
        .i_z_in      (i_z_in),
        .i_last_in   (i_last_in),
        .i_back_busy (w_busy),
        .i_job_pop   (w_job_pop),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_job_vld   (w_job_vld),
        .o_job       (w_job),
        .o_job_n     (w_job_n)
    );

    vbn_ram #(.WIDTH(vbn_pkg::VTX_W), .DEPTH(MAX_VERTICES)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    vbn_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_side      (r_side),
        .i_job_vld   (w_job_vld),
        .i_job       (w_job),
        .i_job_n     (w_job_n),
        .o_job_pop   (w_job_pop),
        .o_busy      (w_busy),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .pop         (pop),
        .empty       (empty),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out),
        .o_z_out     (o_z_out),
        .o_last_out  (o_last_out),
        .o_flat_axes (o_flat_axes),
        .o_dropped   (o_dropped)
    );
endmodule
`default_nettype wire

// File: rtl/core/vbn_checker.sv
// Port-level checker for the normaliser top level, attached by bind.
// Depends on vbn_pkg and vertex_bounding_box_normalizer_top_assert.svh.
`default_nettype none
`include "vertex_bounding_box_normalizer_top_assert.svh"
module vbn_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        push,
    input wire logic                        full,
    input wire logic                        i_last_in,
    input wire logic                        pop,
    input wire logic                        empty,
    input wire logic [vbn_pkg::COORD_W-1:0] o_x_out
);
    `VBN_CHK_NEXT(a_last_stalls, push && !full && i_last_in, full)
    `VBN_CHK_NEXT(a_result_holds, !empty && !pop, !empty)
    `VBN_CHK_NEXT(a_payload_holds, !empty && !pop, $stable(o_x_out))
    `VBN_CHK_RST(a_reset_clears, !i_rst_n, empty && !full)
endmodule

bind vertex_bounding_box_normalizer_top vbn_checker u_vbn_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .push      (push),
    .full      (full),
    .i_last_in (i_last_in),
    .pop       (pop),
    .empty     (empty),
    .o_x_out   (o_x_out)
);
`default_nettype wire
